>>> hdl/bdq_pkg.sv
// Shared constants, types and a helper function for the bounded deque with search.
package bdq_pkg;

  localparam int unsigned DEPTH  = 128;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 3;
  localparam int unsigned STS_W  = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_SEARCH     = 3'd4;

  // Status codes.
  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd1;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd2;
  localparam logic [STS_W-1:0] STS_MISS  = 2'd3;

  typedef struct packed {
    logic [STS_W-1:0] status;
    logic [PTR_W-1:0] position;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic accept;       // input transaction taken this cycle
    logic srch_start;   // reset the search walk
    logic srch_step;    // advance the search walk
    logic sel_srch;     // fresh result comes from the search unit
    logic out_ld_fresh; // load output register with the fresh result
    logic pend_ld;      // park the fresh result in the pending register
    logic out_ld_pend;  // move the pending result to the output register
  } cmd_t;

  typedef struct packed {
    logic is_search;
    logic srch_done;
  } sts_t;

  // Circular slot of (base + off) for off below DEPTH.
  function automatic logic [PTR_W-1:0] slot_add(input logic [PTR_W-1:0] base,
                                                input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> hdl/bdq_ctrl.sv
// Controller state machine sequencing transactions, searches and result delivery.
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  bdq_pkg::sts_t sts_i,
  output bdq_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   result_rdy;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    result_rdy  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_search) begin
            cmd_o.srch_start = 1'b1;
            state_d          = ST_SEARCH;
          end else begin
            result_rdy = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        cmd_o.sel_srch  = 1'b1;
        if (sts_i.srch_done) begin
          result_rdy = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_HOLD: begin
        if (!out_stall_i) begin
          cmd_o.out_ld_pend = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // A finished result goes straight out when the output register frees up,
    // otherwise it is parked until the current result is taken.
    if (result_rdy) begin
      if (out_free) begin
        cmd_o.out_ld_fresh = 1'b1;
        out_valid_d        = 1'b1;
      end else begin
        cmd_o.pend_ld = 1'b1;
        state_d       = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_hold_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_HOLD |-> out_valid_q)
    else $error("pending result held while output register is empty");

  a_search_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH && sts_i.srch_done |=> state_q != ST_SEARCH)
    else $error("search continued after completion");

endmodule

>>> hdl/bdq_dp.sv
// Datapath: entry memory, front pointer, count, search walk and result registers.
module bdq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [bdq_pkg::FUNC_W-1:0]          func_i,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value_i,
  input  bdq_pkg::cmd_t                       cmd_i,
  output bdq_pkg::sts_t                       sts_o,
  output logic [bdq_pkg::STS_W-1:0]           status_o,
  output logic [bdq_pkg::PTR_W-1:0]           position_o,
  output logic [bdq_pkg::CNT_W-1:0]           count_o
);

  logic [bdq_pkg::DATA_W-1:0] mem [bdq_pkg::DEPTH];

  logic [bdq_pkg::PTR_W-1:0]  front_q, front_d;
  logic [bdq_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [bdq_pkg::DATA_W-1:0] key_q;
  logic [bdq_pkg::CNT_W-1:0]  issue_idx_q;
  logic                       cmp_vld_q;
  logic [bdq_pkg::PTR_W-1:0]  cmp_idx_q;
  logic [bdq_pkg::DATA_W-1:0] rd_data_q;
  bdq_pkg::res_t              out_q, pend_q;

  logic                       full, empty;
  logic [bdq_pkg::PTR_W-1:0]  front_inc, front_dec, back_slot;
  logic                       wr_en;
  logic [bdq_pkg::PTR_W-1:0]  wr_addr;
  logic [bdq_pkg::PTR_W-1:0]  rd_addr;
  logic                       issue_more;
  logic                       hit;
  bdq_pkg::res_t              upd_res, srch_res, fresh_res;

  assign full  = (cnt_q == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
  assign empty = (cnt_q == '0);

  assign front_inc = (front_q == bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? bdq_pkg::PTR_W'(bdq_pkg::DEPTH - 1) : front_q - 1'b1;
  assign back_slot = bdq_pkg::slot_add(front_q, cnt_q[bdq_pkg::PTR_W-1:0]);

  always_comb begin
    front_d        = front_q;
    cnt_d          = cnt_q;
    wr_en          = 1'b0;
    wr_addr        = back_slot;
    upd_res.status = bdq_pkg::STS_OK;
    if (cmd_i.accept) begin
      unique case (func_i)
        bdq_pkg::FN_PUSH_FRONT: begin
          if (full) begin
            upd_res.status = bdq_pkg::STS_FULL;
          end else begin
            front_d = front_dec;
            wr_en   = 1'b1;
            wr_addr = front_dec;
            cnt_d   = cnt_q + 1'b1;
          end
        end
        bdq_pkg::FN_PUSH_BACK: begin
          if (full) begin
            upd_res.status = bdq_pkg::STS_FULL;
          end else begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
        end
        bdq_pkg::FN_POP_FRONT: begin
          if (empty) begin
            upd_res.status = bdq_pkg::STS_EMPTY;
          end else begin
            front_d = front_inc;
            cnt_d   = cnt_q - 1'b1;
          end
        end
        bdq_pkg::FN_POP_BACK: begin
          if (empty) begin
            upd_res.status = bdq_pkg::STS_EMPTY;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    upd_res.position = '0;
    upd_res.count    = cnt_d;
  end

  // Search walk: one memory read issued per cycle, compared on the next.
  assign issue_more = (issue_idx_q != cnt_q);
  assign rd_addr    = bdq_pkg::slot_add(front_q, issue_idx_q[bdq_pkg::PTR_W-1:0]);
  assign hit        = cmp_vld_q && (rd_data_q == key_q);

  always_comb begin
    srch_res.count = cnt_q;
    if (hit) begin
      srch_res.status   = bdq_pkg::STS_OK;
      srch_res.position = cmp_idx_q;
    end else begin
      srch_res.status   = bdq_pkg::STS_MISS;
      srch_res.position = '0;
    end
  end

  assign fresh_res = cmd_i.sel_srch ? srch_res : upd_res;

  assign sts_o.is_search = (func_i == bdq_pkg::FN_SEARCH);
  assign sts_o.srch_done = hit || (!issue_more && !cmp_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      issue_idx_q <= '0;
      cmp_vld_q   <= 1'b0;
    end else begin
      front_q <= front_d;
      cnt_q   <= cnt_d;
      if (cmd_i.srch_start) begin
        issue_idx_q <= '0;
        cmp_vld_q   <= 1'b0;
      end else if (cmd_i.srch_step && issue_more) begin
        issue_idx_q <= issue_idx_q + 1'b1;
        cmp_vld_q   <= 1'b1;
      end else begin
        cmp_vld_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= value_i;
    end
    cmp_idx_q <= issue_idx_q[bdq_pkg::PTR_W-1:0];
    if (cmd_i.pend_ld) begin
      pend_q <= fresh_res;
    end
    if (cmd_i.out_ld_fresh) begin
      out_q <= fresh_res;
    end else if (cmd_i.out_ld_pend) begin
      out_q <= pend_q;
    end
  end

  assign status_o   = out_q.status;
  assign position_o = out_q.position;
  assign count_o    = out_q.count;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("entry count exceeds capacity");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_vld_q |-> {1'b0, cmp_idx_q} < cnt_q)
    else $error("search compared an entry outside the held range");

  a_cmp_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmp_vld_q) |-> $past(cmd_i.srch_step))
    else $error("compare stage filled without a search step");

endmodule

>>> hdl/bounded_deque_with_search.sv
// Insert, remove and unused-code results load the output register on acceptance when it is free,
// else they wait in the pending register. Search: one memory read per cycle from the front, each
// compared with the key; the walk stops at the first hit or, as a miss, after the last entry.
// Throughput: one transaction in flight; the next is accepted in the cycle after its result
// reaches the output register. Reset: front pointer, count and handshake state clear.
// Top level of the bounded deque with linear search.
module bounded_deque_with_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [bdq_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [bdq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [bdq_pkg::STS_W-1:0]         status_o,
  output logic [bdq_pkg::PTR_W-1:0]         position_o,
  output logic [bdq_pkg::CNT_W-1:0]         count_o
);

  bdq_pkg::cmd_t cmd;
  bdq_pkg::sts_t sts;

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bdq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .func_i     (func_i),
    .value_i    (value_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .status_o   (status_o),
    .position_o (position_o),
    .count_o    (count_o)
  );

endmodule
